>>> hw/rtl/sphere_segment_support_point_unit_assert.svh
// Assertion macros shared by the sphere slab support point RTL
`ifndef SPHERE_SEGMENT_SUPPORT_POINT_UNIT_ASSERT_SVH
`define SPHERE_SEGMENT_SUPPORT_POINT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssp assertion failed");
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssp assertion failed");
`else
`define SSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/ssp_pkg.sv
// Shared constants and types of the sphere slab support point unit
package ssp_pkg;
    localparam int SSP_DATA_W    = 32;
    localparam int SSP_CFG_W     = 31;
    localparam int SSP_CFG_IDX_W = 1;
    localparam int SSP_SQ_W      = 64;
    localparam int SSP_ROOT_W    = SSP_SQ_W / 2;
    localparam int SSP_NUM_W     = 63;
    localparam int SSP_Q_W       = 31;

    localparam logic [SSP_CFG_IDX_W-1:0] SSP_CFG_RADIUS     = 1'b0;
    localparam logic [SSP_CFG_IDX_W-1:0] SSP_CFG_HALF_WIDTH = 1'b1;

    localparam logic [SSP_CFG_W-1:0] SSP_RADIUS_RST     = 31'd65536;
    localparam logic [SSP_CFG_W-1:0] SSP_HALF_WIDTH_RST = 31'd32768;

    // squared lengths at or below this count as zero
    localparam logic [SSP_SQ_W-1:0] SSP_SQ_EPS = 64'd512;

    typedef struct packed {
        logic signed [SSP_DATA_W-1:0] point_x;
        logic signed [SSP_DATA_W-1:0] point_y;
        logic signed [SSP_DATA_W-1:0] point_z;
        logic                         batch_end_out;
    } t_point;
endpackage

>>> hw/rtl/ssp_stream_if.sv
// Valid/ready stream interfaces for direction items and support point items
interface ssp_dir_if import ssp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SSP_DATA_W-1:0] dir_x;
    logic signed [SSP_DATA_W-1:0] dir_y;
    logic signed [SSP_DATA_W-1:0] dir_z;
    logic                         batch_end;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output batch_end, input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z,
                  input batch_end, output ready);
endinterface

interface ssp_pt_if import ssp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SSP_DATA_W-1:0] point_x;
    logic signed [SSP_DATA_W-1:0] point_y;
    logic signed [SSP_DATA_W-1:0] point_z;
    logic                         batch_end_out;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output batch_end_out, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  input batch_end_out, output ready);
endinterface

>>> hw/rtl/ssp_isqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, several lanes
module ssp_isqrt_pipe import ssp_pkg::*; #(
    parameter int IN_W  = SSP_SQ_W,
    parameter int LANES = 1,
    parameter int SB_W  = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [SB_W-1:0]                   i_sb,
    input  logic [LANES-1:0][IN_W-1:0]        i_rad,
    output logic                              o_valid,
    output logic [SB_W-1:0]                   o_sb,
    output logic [LANES-1:0][IN_W/2-1:0]      o_root
);
    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic                              r_v    [OUT_W];
    logic [SB_W-1:0]                   r_sb   [OUT_W];
    logic [LANES-1:0][IN_W-1:0]        r_rad  [OUT_W];
    logic [LANES-1:0][OUT_W-1:0]       r_root [OUT_W];
    logic [LANES-1:0][REM_W-1:0]       r_rem  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stg
        localparam int B = OUT_W - 1 - k;
        logic                        v_d;
        logic [SB_W-1:0]             sb_d;
        logic [LANES-1:0][IN_W-1:0]  rad_d;
        logic [LANES-1:0][OUT_W-1:0] root_d;
        logic [LANES-1:0][REM_W-1:0] rem_d;
        logic [LANES-1:0][REM_W-1:0] sh;
        logic [LANES-1:0][REM_W-1:0] trial;
        logic [LANES-1:0][OUT_W-1:0] n_root;
        logic [LANES-1:0][REM_W-1:0] n_rem;

        if (k == 0) begin : g_head
            assign v_d    = i_valid;
            assign sb_d   = i_sb;
            assign rad_d  = i_rad;
            assign root_d = '0;
            assign rem_d  = '0;
        end else begin : g_tail
            assign v_d    = r_v[k-1];
            assign sb_d   = r_sb[k-1];
            assign rad_d  = r_rad[k-1];
            assign root_d = r_root[k-1];
            assign rem_d  = r_rem[k-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                sh[l]    = {rem_d[l][OUT_W-1:0], rad_d[l][2*B+1 -: 2]};
                trial[l] = {root_d[l], 2'b01};
                if (sh[l] >= trial[l]) begin
                    n_rem[l]  = sh[l] - trial[l];
                    n_root[l] = {root_d[l][OUT_W-2:0], 1'b1};
                end else begin
                    n_rem[l]  = sh[l];
                    n_root[l] = {root_d[l][OUT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_d;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[k]   <= sb_d;
                r_rad[k]  <= rad_d;
                r_root[k] <= n_root;
                r_rem[k]  <= n_rem;
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_sb    = r_sb[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
endmodule

>>> hw/rtl/ssp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor
module ssp_div_pipe import ssp_pkg::*; #(
    parameter int NUM_W = SSP_NUM_W,
    parameter int DEN_W = SSP_ROOT_W,
    parameter int Q_W   = SSP_Q_W,
    parameter int LANES = 1,
    parameter int SB_W  = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [SB_W-1:0]             i_sb,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_valid,
    output logic [SB_W-1:0]             o_sb,
    output logic [LANES-1:0][Q_W-1:0]   o_q
);
    // quotient must fit in Q_W bits, so the top numerator bits start below the divisor
    logic                        r_v   [Q_W];
    logic [SB_W-1:0]             r_sb  [Q_W];
    logic [LANES-1:0][NUM_W-1:0] r_num [Q_W];
    logic [DEN_W-1:0]            r_den [Q_W];
    logic [LANES-1:0][DEN_W-1:0] r_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_q   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stg
        localparam int B = Q_W - 1 - k;
        logic                        v_d;
        logic [SB_W-1:0]             sb_d;
        logic [LANES-1:0][NUM_W-1:0] num_d;
        logic [DEN_W-1:0]            den_d;
        logic [LANES-1:0][DEN_W-1:0] rem_d;
        logic [LANES-1:0][Q_W-1:0]   q_d;
        logic [LANES-1:0][DEN_W:0]   cat;
        logic [LANES-1:0][DEN_W:0]   dif;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_q;

        if (k == 0) begin : g_head
            assign v_d   = i_valid;
            assign sb_d  = i_sb;
            assign num_d = i_num;
            assign den_d = i_den;
            assign q_d   = '0;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_d[l] = DEN_W'(i_num[l][NUM_W-1:Q_W]);
                end
            end
        end else begin : g_tail
            assign v_d   = r_v[k-1];
            assign sb_d  = r_sb[k-1];
            assign num_d = r_num[k-1];
            assign den_d = r_den[k-1];
            assign rem_d = r_rem[k-1];
            assign q_d   = r_q[k-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                cat[l] = {rem_d[l], num_d[l][B]};
                dif[l] = cat[l] - {1'b0, den_d};
                if (cat[l] >= {1'b0, den_d}) begin
                    n_rem[l] = dif[l][DEN_W-1:0];
                    n_q[l]   = {q_d[l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = cat[l][DEN_W-1:0];
                    n_q[l]   = {q_d[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_d;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[k]  <= sb_d;
                r_num[k] <= num_d;
                r_den[k] <= den_d;
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];
    assign o_q     = r_q[Q_W-1];
endmodule

>>> hw/rtl/ssp_out_buf.sv
// Output register with skid stage; upstream ready comes from a flop
`include "sphere_segment_support_point_unit_assert.svh"
module ssp_out_buf import ssp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_point i_data,
    output logic   o_ready,
    output logic   o_valid,
    output t_point o_data,
    input  logic   i_ready
);
    logic   r_out_v, n_out_v;
    logic   r_skid_v, n_skid_v;
    t_point r_out_d, n_out_d;
    t_point r_skid_d, n_skid_d;
    logic   take;
    logic   pop;

    assign take = i_valid && !r_skid_v;
    assign pop  = r_out_v && i_ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_out_d  = r_out_d;
        n_skid_v = r_skid_v;
        n_skid_d = r_skid_d;
        if (pop) begin
            if (r_skid_v) begin
                n_out_d  = r_skid_d;
                n_skid_v = 1'b0;
            end else if (take) begin
                n_out_d = i_data;
            end else begin
                n_out_v = 1'b0;
            end
        end else if (take) begin
            if (r_out_v) begin
                n_skid_d = i_data;
                n_skid_v = 1'b1;
            end else begin
                n_out_d = i_data;
                n_out_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_d  <= n_out_d;
        r_skid_d <= n_skid_d;
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out_d;

    `SSP_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `SSP_ASSERT_NEXT(a_skid_fills, i_clk, i_rst_n, i_valid && !r_skid_v && r_out_v && !i_ready, r_skid_v)
    `SSP_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && i_ready, !r_skid_v && r_out_v && (r_out_d == $past(r_skid_d)))
endmodule

>>> hw/rtl/sphere_segment_support_point_unit.sv
// Throughput: one item per cycle while ready is high; two square roots (32 stages each)
// and two dividers (31 stages each) are fully pipelined, one bit per stage.
// Ready is low only while the output skid stage holds an item; the whole pipe then holds.
// Reset: synchronous active low; clears all valid bits, radius to 1.0, half width to 0.5.
module sphere_segment_support_point_unit import ssp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SSP_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SSP_CFG_W-1:0]     i_cfg_wdata,
    ssp_dir_if.sink                  i_dir,
    ssp_pt_if.source                 o_pt
);
    typedef struct packed {
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [30:0] radius;
        logic [30:0] half_width;
        logic        tiny;
        logic        batch_end;
    } t_sb_len;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [30:0] half_width;
        logic [30:0] side;
        logic        tiny;
        logic        batch_end;
    } t_sb_dir;

    typedef struct packed {
        logic [30:0] q_x;
        logic [30:0] q_y;
        logic [30:0] q_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [30:0] half_width;
        logic [30:0] side;
        logic        tiny;
        logic        clip;
        logic        pflag;
        logic        batch_end;
    } t_sb_cut;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [31:0] signed_of(input logic neg, input logic [30:0] m);
        logic [31:0] u;
        u = neg ? (~{1'b0, m} + 32'd1) : {1'b0, m};
        return $signed(u);
    endfunction

    // configuration
    logic [SSP_CFG_W-1:0] r_radius;
    logic [SSP_CFG_W-1:0] r_half_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= SSP_RADIUS_RST;
            r_half_width <= SSP_HALF_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                SSP_CFG_RADIUS:     r_radius     <= i_cfg_wdata;
                SSP_CFG_HALF_WIDTH: r_half_width <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic pipe_en;
    assign i_dir.ready = pipe_en;

    // stage 1: capture item and registers
    logic        r1_v;
    logic [31:0] r1_dx, r1_dy, r1_dz;
    logic        r1_be;
    logic [30:0] r1_r, r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (pipe_en) begin
            r1_v <= i_dir.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_dx <= i_dir.dir_x;
            r1_dy <= i_dir.dir_y;
            r1_dz <= i_dir.dir_z;
            r1_be <= i_dir.batch_end;
            r1_r  <= r_radius;
            r1_w  <= r_half_width;
        end
    end

    // stage 2: squares
    logic [31:0] mag_x, mag_y, mag_z;
    logic [63:0] sq_x, sq_y, sq_z;
    logic        r2_v;
    logic [62:0] r2_sq_x, r2_sq_y, r2_sq_z;
    logic [61:0] r2_rsq, r2_wsq;
    t_sb_len     r2_sb;

    assign mag_x = mag32(r1_dx);
    assign mag_y = mag32(r1_dy);
    assign mag_z = mag32(r1_dz);
    assign sq_x  = 64'(mag_x) * 64'(mag_x);
    assign sq_y  = 64'(mag_y) * 64'(mag_y);
    assign sq_z  = 64'(mag_z) * 64'(mag_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (pipe_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_sq_x          <= sq_x[62:0];
            r2_sq_y          <= sq_y[62:0];
            r2_sq_z          <= sq_z[62:0];
            r2_rsq           <= 62'(r1_r) * 62'(r1_r);
            r2_wsq           <= 62'(r1_w) * 62'(r1_w);
            r2_sb.mag_x      <= mag_x;
            r2_sb.mag_y      <= mag_y;
            r2_sb.mag_z      <= mag_z;
            r2_sb.neg_x      <= r1_dx[31];
            r2_sb.neg_y      <= r1_dy[31];
            r2_sb.neg_z      <= r1_dz[31];
            r2_sb.radius     <= r1_r;
            r2_sb.half_width <= r1_w;
            r2_sb.tiny       <= 1'b0;
            r2_sb.batch_end  <= r1_be;
        end
    end

    // stage 3: squared length and squared cut circle radius
    logic [63:0] lsq_sum;
    logic        r3_v;
    logic [63:0] r3_lsq, r3_side_rad;
    t_sb_len     r3_sb;
    t_sb_len     n_sb3;

    assign lsq_sum = 64'(r2_sq_x) + 64'(r2_sq_y) + 64'(r2_sq_z);

    always_comb begin
        n_sb3      = r2_sb;
        n_sb3.tiny = (lsq_sum <= SSP_SQ_EPS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (pipe_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_lsq      <= lsq_sum;
            r3_side_rad <= (r2_sb.radius > r2_sb.half_width) ? 64'(r2_rsq - r2_wsq) : '0;
            r3_sb       <= n_sb3;
        end
    end

    // length and cut circle radius roots
    logic                             sq1_v;
    logic [$bits(t_sb_len)-1:0]       sq1_sb_bits;
    logic [1:0][SSP_ROOT_W-1:0]       sq1_root;
    t_sb_len                          sq1_sb;

    ssp_isqrt_pipe #(
        .IN_W  (SSP_SQ_W),
        .LANES (2),
        .SB_W  ($bits(t_sb_len))
    ) u_isqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r3_v),
        .i_sb    (r3_sb),
        .i_rad   ({r3_side_rad, r3_lsq}),
        .o_valid (sq1_v),
        .o_sb    (sq1_sb_bits),
        .o_root  (sq1_root)
    );

    assign sq1_sb = t_sb_len'(sq1_sb_bits);

    // stage 4: numerators for scaling to the radius
    logic        r4_v;
    logic [62:0] r4_num_x, r4_num_y, r4_num_z;
    logic [31:0] r4_len;
    t_sb_dir     r4_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (pipe_en) begin
            r4_v <= sq1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_num_x         <= 63'(sq1_sb.mag_x) * 63'(sq1_sb.radius);
            r4_num_y         <= 63'(sq1_sb.mag_y) * 63'(sq1_sb.radius);
            r4_num_z         <= 63'(sq1_sb.mag_z) * 63'(sq1_sb.radius);
            r4_len           <= sq1_root[0];
            r4_sb.neg_x      <= sq1_sb.neg_x;
            r4_sb.neg_y      <= sq1_sb.neg_y;
            r4_sb.neg_z      <= sq1_sb.neg_z;
            r4_sb.half_width <= sq1_sb.half_width;
            r4_sb.side       <= sq1_root[1][30:0];
            r4_sb.tiny       <= sq1_sb.tiny;
            r4_sb.batch_end  <= sq1_sb.batch_end;
        end
    end

    logic                       dv1_v;
    logic [$bits(t_sb_dir)-1:0] dv1_sb_bits;
    logic [2:0][SSP_Q_W-1:0]    dv1_q;
    t_sb_dir                    dv1_sb;

    ssp_div_pipe #(
        .NUM_W (SSP_NUM_W),
        .DEN_W (SSP_ROOT_W),
        .Q_W   (SSP_Q_W),
        .LANES (3),
        .SB_W  ($bits(t_sb_dir))
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r4_v),
        .i_sb    (r4_sb),
        .i_num   ({r4_num_z, r4_num_y, r4_num_x}),
        .i_den   (r4_len),
        .o_valid (dv1_v),
        .o_sb    (dv1_sb_bits),
        .o_q     (dv1_q)
    );

    assign dv1_sb = t_sb_dir'(dv1_sb_bits);

    // stage 5: clip test and squares of the side components
    logic        r5_v;
    logic [61:0] r5_qy2, r5_qz2;
    t_sb_cut     r5_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (pipe_en) begin
            r5_v <= dv1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_qy2           <= 62'(dv1_q[1]) * 62'(dv1_q[1]);
            r5_qz2           <= 62'(dv1_q[2]) * 62'(dv1_q[2]);
            r5_sb.q_x        <= dv1_q[0];
            r5_sb.q_y        <= dv1_q[1];
            r5_sb.q_z        <= dv1_q[2];
            r5_sb.neg_x      <= dv1_sb.neg_x;
            r5_sb.neg_y      <= dv1_sb.neg_y;
            r5_sb.neg_z      <= dv1_sb.neg_z;
            r5_sb.half_width <= dv1_sb.half_width;
            r5_sb.side       <= dv1_sb.side;
            r5_sb.tiny       <= dv1_sb.tiny;
            r5_sb.clip       <= (dv1_q[0] > dv1_sb.half_width);
            r5_sb.pflag      <= 1'b0;
            r5_sb.batch_end  <= dv1_sb.batch_end;
        end
    end

    // stage 6: squared length of the side part
    logic [63:0] plsq_sum;
    logic        r6_v;
    logic [63:0] r6_plsq;
    t_sb_cut     r6_sb;
    t_sb_cut     n_sb6;

    assign plsq_sum = 64'(r5_qy2) + 64'(r5_qz2);

    always_comb begin
        n_sb6       = r5_sb;
        n_sb6.pflag = (plsq_sum > SSP_SQ_EPS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (pipe_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r6_plsq <= plsq_sum;
            r6_sb   <= n_sb6;
        end
    end

    logic                       sq2_v;
    logic [$bits(t_sb_cut)-1:0] sq2_sb_bits;
    logic [0:0][SSP_ROOT_W-1:0] sq2_root;
    t_sb_cut                    sq2_sb;

    ssp_isqrt_pipe #(
        .IN_W  (SSP_SQ_W),
        .LANES (1),
        .SB_W  ($bits(t_sb_cut))
    ) u_isqrt_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r6_v),
        .i_sb    (r6_sb),
        .i_rad   (r6_plsq),
        .o_valid (sq2_v),
        .o_sb    (sq2_sb_bits),
        .o_root  (sq2_root)
    );

    assign sq2_sb = t_sb_cut'(sq2_sb_bits);

    // stage 7: numerators for scaling onto the cut circle
    logic        r7_v;
    logic [62:0] r7_num_y, r7_num_z;
    logic [31:0] r7_plen;
    t_sb_cut     r7_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (pipe_en) begin
            r7_v <= sq2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r7_num_y <= 63'(sq2_sb.q_y) * 63'(sq2_sb.side);
            r7_num_z <= 63'(sq2_sb.q_z) * 63'(sq2_sb.side);
            r7_plen  <= sq2_root[0];
            r7_sb    <= sq2_sb;
        end
    end

    logic                       dv2_v;
    logic [$bits(t_sb_cut)-1:0] dv2_sb_bits;
    logic [1:0][SSP_Q_W-1:0]    dv2_q;
    t_sb_cut                    dv2_sb;

    ssp_div_pipe #(
        .NUM_W (SSP_NUM_W),
        .DEN_W (SSP_ROOT_W),
        .Q_W   (SSP_Q_W),
        .LANES (2),
        .SB_W  ($bits(t_sb_cut))
    ) u_div_cut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r7_v),
        .i_sb    (r7_sb),
        .i_num   ({r7_num_z, r7_num_y}),
        .i_den   (r7_plen),
        .o_valid (dv2_v),
        .o_sb    (dv2_sb_bits),
        .o_q     (dv2_q)
    );

    assign dv2_sb = t_sb_cut'(dv2_sb_bits);

    // result select
    t_point pt;

    always_comb begin
        pt.batch_end_out = dv2_sb.batch_end;
        if (dv2_sb.tiny) begin
            pt.point_x = '0;
            pt.point_y = '0;
            pt.point_z = '0;
        end else if (!dv2_sb.clip) begin
            pt.point_x = signed_of(dv2_sb.neg_x, dv2_sb.q_x);
            pt.point_y = signed_of(dv2_sb.neg_y, dv2_sb.q_y);
            pt.point_z = signed_of(dv2_sb.neg_z, dv2_sb.q_z);
        end else if (dv2_sb.pflag) begin
            pt.point_x = signed_of(dv2_sb.neg_x, dv2_sb.half_width);
            pt.point_y = signed_of(dv2_sb.neg_y, dv2_q[0]);
            pt.point_z = signed_of(dv2_sb.neg_z, dv2_q[1]);
        end else begin
            // direction along the axis: point sits on the rim toward +y
            pt.point_x = signed_of(dv2_sb.neg_x, dv2_sb.half_width);
            pt.point_y = signed_of(1'b0, dv2_sb.side);
            pt.point_z = '0;
        end
    end

    t_point out_d;

    ssp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv2_v),
        .i_data  (pt),
        .o_ready (pipe_en),
        .o_valid (o_pt.valid),
        .o_data  (out_d),
        .i_ready (o_pt.ready)
    );

    assign o_pt.point_x       = out_d.point_x;
    assign o_pt.point_y       = out_d.point_y;
    assign o_pt.point_z       = out_d.point_z;
    assign o_pt.batch_end_out = out_d.batch_end_out;
endmodule
